@@ sv/multichannel_fir_ring_filter_macros.svh @@
// Assertion helpers for the FIR ring filter.
`ifndef MULTICHANNEL_FIR_RING_FILTER_MACROS_SVH
`define MULTICHANNEL_FIR_RING_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFRF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfrf assertion failed");

// Next-cycle implication, disabled during reset.
`define MFRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfrf assertion failed");

`endif

@@ sv/mfrf_pkg.sv @@
package mfrf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = 48;
  localparam int FRAC_W      = 15;
  localparam int TAP_IDX_W   = 8;
  localparam int TAP_COUNT_W = 9;
  localparam int CHAN_W      = 1;

  localparam int CHANNELS_DEF      = 2;
  localparam int TAPS_MAX_DEF      = 256;
  localparam int HISTORY_DEPTH_DEF = 256;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(256);
  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND
  } state_t;

endpackage

@@ sv/mfrf_if.sv @@
interface mfrf_item_if import mfrf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [CHAN_W-1:0]           channel;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [COEF_W-1:0]    coefficient;
  logic signed [SAMPLE_W-1:0]  sample;

  modport source (output valid, mode, channel, tap_index, coefficient, sample, input ready);
  modport sink   (input valid, mode, channel, tap_index, coefficient, sample, output ready);
endinterface

interface mfrf_result_if import mfrf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CHAN_W-1:0]           out_channel;
  logic signed [SAMPLE_W-1:0]  filtered;
  logic                        saturated;

  modport source (output valid, out_channel, filtered, saturated, input ready);
  modport sink   (input valid, out_channel, filtered, saturated, output ready);
endinterface

@@ sv/multichannel_fir_ring_filter.sv @@
// Sample beat: the single shared multiply-accumulate sums tap_count taps (tap_count
// clamped to TAPS_MAX) and registers the rounded result; the next sample beat is taken
// only once that result is loaded into the output register, which can wait on result.ready.
// Coefficient load beats are taken one per cycle while idle and give no result.
// Reset (rst, synchronous): write positions zeroed, tap_count set to 256, then a clearing
// pass zeroes the CHANNELS * HISTORY_DEPTH history words before beats are taken.
`include "multichannel_fir_ring_filter_macros.svh"

module multichannel_fir_ring_filter import mfrf_pkg::*; #(
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int TAPS_MAX      = TAPS_MAX_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [TAP_COUNT_W-1:0] cfg_wdata,
  mfrf_item_if.sink              item,
  mfrf_result_if.source          result
);

  localparam int HIST_WORDS = CHANNELS * HISTORY_DEPTH;
  localparam int COEF_WORDS = CHANNELS * TAPS_MAX;
  localparam int HA_W       = $clog2(HIST_WORDS);
  localparam int CA_W       = $clog2(COEF_WORDS);
  localparam int PW         = $clog2(HISTORY_DEPTH);
  localparam int TI_W       = $clog2(TAPS_MAX);
  localparam int TC_W       = $clog2(TAPS_MAX + 1);
  localparam int TOP_LSB    = FRAC_W + SAMPLE_W - 1;

  state_t state, state_next;

  logic [HA_W-1:0]            clr_cnt;
  logic [TAP_COUNT_W-1:0]     tap_count;
  logic [PW-1:0]              wp [CHANNELS];

  logic [CHAN_W-1:0]          ch;
  logic [PW-1:0]              pos;
  logic [TI_W-1:0]            tap;
  logic [TC_W-1:0]            rem;

  logic                       rd_v;
  logic                       prod_v;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           acc;

  logic signed [SAMPLE_W-1:0] hist_mem [HIST_WORDS];
  logic signed [COEF_W-1:0]   coef_mem [COEF_WORDS];

  logic                       beat_in;
  logic                       ch_ok;
  logic                       tap_ok;
  logic                       load_acc;
  logic                       filt_acc;
  logic                       issue;
  logic                       out_load;
  logic                       hist_we;
  logic [HA_W-1:0]            hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic [HA_W-1:0]            hist_raddr;
  logic [CA_W-1:0]            coef_waddr;
  logic [CA_W-1:0]            coef_raddr;
  logic [TC_W-1:0]            taps_clamped;
  logic [ACC_W:0]             rsum;
  logic                       sat;
  logic [SAMPLE_W-1:0]        rounded;

  // Beat decode
  assign beat_in  = item.valid && item.ready;
  assign ch_ok    = 32'(item.channel) < CHANNELS;
  assign tap_ok   = 32'(item.tap_index) < TAPS_MAX;
  assign load_acc = beat_in && ch_ok && (item.mode == MODE_LOAD) && tap_ok;
  assign filt_acc = beat_in && ch_ok && (item.mode == MODE_FILTER);

  assign taps_clamped = TC_W'((32'(tap_count) > TAPS_MAX) ? TAPS_MAX : 32'(tap_count));

  assign coef_waddr = CA_W'(item.channel) * CA_W'(TAPS_MAX) + CA_W'(item.tap_index);
  assign coef_raddr = CA_W'(ch) * CA_W'(TAPS_MAX) + CA_W'(tap);
  assign hist_raddr = HA_W'(ch) * HA_W'(HISTORY_DEPTH) + HA_W'(pos);

  // Round half up, floor shift, then clip
  assign rsum    = {acc[ACC_W-1], acc} + (ACC_W+1)'(ROUND_BIAS);
  assign sat     = (rsum[ACC_W:TOP_LSB] != '0) && (rsum[ACC_W:TOP_LSB] != '1);
  assign rounded = sat ? (rsum[ACC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}})
                       : rsum[TOP_LSB:FRAC_W];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == HA_W'(HIST_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (filt_acc) state_next = S_MAC;
      end
      S_MAC: begin
        if (rem == '0) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_v && !prod_v) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    item.ready = (state == S_IDLE);
    issue      = (state == S_MAC) && (rem != '0);
    out_load   = (state == S_ROUND) && (!result.valid || result.ready);
    hist_we    = 1'b0;
    hist_waddr = clr_cnt;
    hist_wdata = '0;
    if (state == S_CLEAR) begin
      hist_we = 1'b1;
    end else if (filt_acc) begin
      hist_we    = 1'b1;
      hist_waddr = HA_W'(item.channel) * HA_W'(HISTORY_DEPTH) + HA_W'(wp[item.channel]);
      hist_wdata = item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      tap_count <= TAP_COUNT_RESET;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) wp[i] <= '0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      prod_v <= rd_v;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) tap_count <= cfg_wdata;
      if (filt_acc) begin
        wp[item.channel] <= (wp[item.channel] == PW'(HISTORY_DEPTH - 1)) ? '0
                                                                         : wp[item.channel] + 1'b1;
      end
    end
  end

  // Tap sequencer and multiply-accumulate
  always_ff @(posedge clk) begin
    if (filt_acc) begin
      ch  <= item.channel;
      pos <= wp[item.channel];
      tap <= '0;
      rem <= taps_clamped;
      acc <= '0;
    end else begin
      if (issue) begin
        rem <= rem - 1'b1;
        tap <= tap + 1'b1;
        pos <= (pos == '0) ? PW'(HISTORY_DEPTH - 1) : pos - 1'b1;
      end
      if (prod_v) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (rd_v) prod <= coef_q * hist_q;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_acc) coef_mem[coef_waddr] <= item.coefficient;
    coef_q <= coef_mem[coef_raddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_channel <= ch;
      result.filtered    <= rounded;
      result.saturated   <= sat;
    end
  end

  `MFRF_ASSERT_NOW(a_no_result_in_clear, clk, rst, state == S_CLEAR, !result.valid)
  `MFRF_ASSERT_NEXT(a_filter_starts, clk, rst, filt_acc, state == S_MAC)
  `MFRF_ASSERT_NOW(a_reads_in_mac, clk, rst, rd_v || prod_v, state == S_MAC || state == S_DRAIN)
  `MFRF_ASSERT_NOW(a_sat_at_rail, clk, rst, result.valid && result.saturated,
                   result.filtered == 16'sh7fff || result.filtered == 16'sh8000)

endmodule

@@ sim/multichannel_fir_ring_filter_tb.sv @@
`timescale 1ns / 1ps

module multichannel_fir_ring_filter_tb;
  import mfrf_pkg::*;

  localparam int CHANS = CHANNELS_DEF;
  localparam int TAPS  = TAPS_MAX_DEF;
  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int POS_W = $clog2(DEPTH);

  typedef struct {
    logic [CHAN_W-1:0]          out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } fir_out_t;

  class fir_ring_shadow;
    logic signed [SAMPLE_W-1:0] hist [CHANS][DEPTH];
    logic signed [COEF_W-1:0]   coefs [CHANS][TAPS];
    logic [POS_W-1:0]           wpos [CHANS];
    logic [TAP_COUNT_W-1:0]     taps_used;
    fir_out_t                   pending_out [$];
    int                         mismatches;
    int                         loads;
    int                         filters;
    int                         checked;

    function new();
      for (int c = 0; c < CHANS; c++) begin
        wpos[c] = '0;
        for (int d = 0; d < DEPTH; d++) hist[c][d] = '0;
      end
      taps_used  = TAP_COUNT_RESET;
      mismatches = 0;
      loads      = 0;
      filters    = 0;
      checked    = 0;
    endfunction

    function void set_tap_count(logic [TAP_COUNT_W-1:0] v);
      taps_used = v;
    endfunction

    function void take_beat(logic mode, logic [CHAN_W-1:0] ch, logic [TAP_IDX_W-1:0] tap,
                            logic signed [COEF_W-1:0] c, logic signed [SAMPLE_W-1:0] s);
      fir_out_t                  o;
      logic signed [ACC_W-1:0]   acc;
      logic signed [PROD_W-1:0]  prod;
      logic [POS_W-1:0]          pos;
      longint                    rounded;
      int                        n;
      if (mode == MODE_LOAD) begin
        coefs[ch][tap] = c;
        loads++;
        return;
      end
      filters++;
      hist[ch][wpos[ch]] = s;
      n = (taps_used > TAPS) ? TAPS : int'(taps_used);
      acc = '0;
      for (int j = 0; j < n; j++) begin
        pos  = wpos[ch] - POS_W'(j);
        prod = coefs[ch][j] * hist[ch][pos];
        acc  = acc + prod;
      end
      wpos[ch] = wpos[ch] + 1'b1;
      // round half up, floor shift
      rounded = (longint'(acc) + ROUND_BIAS) >>> FRAC_W;
      o.saturated = 1'b0;
      if (rounded > 32767) begin
        rounded     = 32767;
        o.saturated = 1'b1;
      end else if (rounded < -32768) begin
        rounded     = -32768;
        o.saturated = 1'b1;
      end
      o.out_channel = ch;
      o.filtered    = rounded[SAMPLE_W-1:0];
      pending_out = {pending_out, o};
    endfunction

    function void check_beat(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] f, logic sat);
      fir_out_t e;
      if (pending_out.size() == 0) begin
        $error("out_channel: no output pending, got channel %0d value %0d", ch, f);
        mismatches++;
        return;
      end
      e = pending_out.pop_front();
      checked++;
      if (ch !== e.out_channel) begin
        $error("out_channel: expected %0d, got %0d", e.out_channel, ch);
        mismatches++;
      end
      if (f !== e.filtered) begin
        $error("filtered: expected %0d, got %0d", e.filtered, f);
        mismatches++;
      end
      if (sat !== e.saturated) begin
        $error("saturated: expected %0d, got %0d", e.saturated, sat);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [TAP_COUNT_W-1:0] cfg_wdata;

  mfrf_item_if   item_bus ();
  mfrf_result_if result_bus ();

  fir_ring_shadow shadow = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_off_left   = 0;
  int tap_settings    = 0;
  int phase_taps [8]  = '{12, 256, 0, 3, 511, 1, 30, 257};

  multichannel_fir_ring_filter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_bus),
    .result   (result_bus)
  );

  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_off_left--;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready)
        shadow.check_beat(result_bus.out_channel, result_bus.filtered, result_bus.saturated);
    end
  end

  function automatic logic signed [COEF_W-1:0] rand_coef();
    unique case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return COEF_W'($urandom);
      4:       return '0;
      default: return COEF_W'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    unique case ($urandom_range(15))
      0, 1:    return 16'sh7FFF;
      2, 3:    return 16'sh8000;
      4:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic push_beat(input logic mode, input logic [CHAN_W-1:0] ch,
                           input logic [TAP_IDX_W-1:0] tap,
                           input logic signed [COEF_W-1:0] c,
                           input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.mode        <= mode;
    item_bus.channel     <= ch;
    item_bus.tap_index   <= tap;
    item_bus.coefficient <= c;
    item_bus.sample      <= s;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    shadow.take_beat(mode, ch, tap, c, s);
    @(negedge clk);
  endtask

  task automatic push_random_beat();
    if ($urandom_range(9) < 2)
      push_beat(MODE_LOAD, CHAN_W'($urandom_range(CHANS - 1)), TAP_IDX_W'($urandom),
                rand_coef(), SAMPLE_W'($urandom));
    else
      push_beat(MODE_FILTER, CHAN_W'($urandom_range(CHANS - 1)), TAP_IDX_W'($urandom),
                COEF_W'($urandom), rand_sample());
  endtask

  // loads leave no output behind, so also allow time for the last one
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (shadow.pending_out.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.set_tap_count(v);
    tap_settings++;
  endtask

  task automatic set_idling(input int s, input int r);
    @(posedge clk);
    sender_idle_pct = s;
    recv_stall_pct  = r;
    @(negedge clk);
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    item_bus.valid       = 1'b0;
    item_bus.mode        = MODE_LOAD;
    item_bus.channel     = '0;
    item_bus.tap_index   = '0;
    item_bus.coefficient = '0;
    item_bus.sample      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every tap of both channels, mostly small so long sums stay in range
    for (int c = 0; c < CHANS; c++)
      for (int t = 0; t < TAPS; t++)
        push_beat(MODE_LOAD, CHAN_W'(c), TAP_IDX_W'(t),
                  (t == 0) ? ((c == 0) ? 16'sh7FFF : 16'sh8000) :
                  (t == TAPS - 1) ? ((c == 0) ? 16'sh8000 : 16'sh7FFF) :
                  COEF_W'(int'($urandom_range(2047)) - 1024),
                  SAMPLE_W'($urandom));

    // reset tap count
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh7FFF);
    push_beat(MODE_FILTER, CHAN_W'(1), 8'hFF, 16'sh7FFF, 16'sh8000);
    push_beat(MODE_LOAD, CHAN_W'(0), 8'hFF, 16'sh8000, '0);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh8000);

    // single tap: positive clip, near full scale, rounding at the half
    settle();
    write_tap_count(TAP_COUNT_W'(1));
    push_beat(MODE_LOAD, CHAN_W'(0), '0, 16'sh8000, '0);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh8000);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh7FFF);
    push_beat(MODE_LOAD, CHAN_W'(1), '0, 16'sh4000, '0);
    push_beat(MODE_FILTER, CHAN_W'(1), '0, '0, 16'sh0001);
    push_beat(MODE_FILTER, CHAN_W'(1), '0, '0, -16'sh0001);

    // two taps: negative clip
    settle();
    write_tap_count(TAP_COUNT_W'(2));
    push_beat(MODE_LOAD, CHAN_W'(0), 8'h01, 16'sh8000, '0);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh7FFF);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh7FFF);

    // empty sum
    settle();
    write_tap_count(TAP_COUNT_W'(0));
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, 16'sh04D2);
    push_beat(MODE_FILTER, CHAN_W'(1), '0, '0, -16'sh0005);

    // above the tap maximum
    settle();
    write_tap_count(9'h1FF);
    push_beat(MODE_FILTER, CHAN_W'(1), '0, '0, 16'sh0064);
    push_beat(MODE_FILTER, CHAN_W'(0), '0, '0, -16'sh0064);

    // output held off long enough to back up the input
    settle();
    write_tap_count(TAP_COUNT_W'(4));
    set_idling(0, 0);
    @(posedge clk);
    hold_off_left = 400;
    @(negedge clk);
    repeat (16)
      push_beat(MODE_FILTER, CHAN_W'($urandom_range(CHANS - 1)), TAP_IDX_W'($urandom),
                COEF_W'($urandom), rand_sample());

    for (int p = 0; p < 8; p++) begin
      settle();
      write_tap_count(TAP_COUNT_W'(phase_taps[p]));
      unique case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(79, 0);
        2: set_idling(0, 79);
        default: set_idling(26, 26);
      endcase
      repeat (60) push_random_beat();
    end

    settle();
    repeat (300) @(negedge clk);
    if (shadow.pending_out.size() != 0) begin
      $error("filtered: %0d outputs never arrived", shadow.pending_out.size());
      shadow.mismatches++;
    end
    $display("Checked %0d filter outputs from %0d sample beats and %0d coefficient loads,",
             shadow.checked, shadow.filters, shadow.loads);
    $display("over %0d tap count settings with idle, stall and long hold-off phases.",
             tap_settings + 1);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ multichannel_fir_ring_filter.f @@
+incdir+sv
sv/mfrf_pkg.sv
sv/mfrf_if.sv
sv/multichannel_fir_ring_filter.sv
sim/multichannel_fir_ring_filter_tb.sv
